/* design/rtb_pkg.sv */
// Package for the rewindable token buffer.
// Item types, operation and status codes, cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtb_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int TOKEN_BITS_DEF = 32;
    localparam int IN_TOK_W       = 32;
    localparam int OUT_TOK_W      = 32;
    localparam int COUNT_W        = 7;

    typedef enum logic [1:0] {
        FN_ADVANCE = 2'd0,
        FN_INSERT  = 2'd1,
        FN_POP     = 2'd2,
        FN_BACK    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel_en;
    } t_cell_ctl;

    typedef struct packed {
        t_func                 func;
        logic [IN_TOK_W-1:0]   token_value;
    } t_in;

    typedef struct packed {
        logic [OUT_TOK_W-1:0]  token_out;
        logic                  took_input;
        logic [COUNT_W-1:0]    cursor;
        logic [COUNT_W-1:0]    fill;
        t_status               status;
    } t_out;

endpackage
`default_nettype wire

/* design/rewindable_token_buffer_unit.sv */
// Rewindable token buffer: cursor and fill control over a chain of cells.
// Depends on rtb_pkg and rtb_cell.
// The result strobe comes in the cycle after the item is accepted.
// Throughput: one item per cycle while busy is low; all cells of the chain shift together.
// Reset: cursor and fill clear, busy high during reset; no clearing pass.
// Results cannot be stalled: o_valid is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module rewindable_token_buffer_unit #(
    parameter int DEPTH      = rtb_pkg::DEPTH_DEF,
    parameter int TOKEN_BITS = rtb_pkg::TOKEN_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire rtb_pkg::t_in i_item,
    output logic              o_valid,
    output rtb_pkg::t_out     o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic          r_busy;
    logic          r_valid;
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] n_cursor;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    rtb_pkg::t_out r_result;
    rtb_pkg::t_out n_result;

    rtb_pkg::t_cell_ctl    ctl;
    logic [CW-1:0]         pos;
    logic [CW-1:0]         sel_idx;
    logic [TOKEN_BITS-1:0] tok;
    logic                  take;
    logic                  full;
    logic                  use_tok;
    logic                  popped;
    rtb_pkg::t_status      status;
    logic [TOKEN_BITS-1:0] sel_or;

    logic [TOKEN_BITS-1:0] cell_val [DEPTH];
    logic [TOKEN_BITS-1:0] cell_sel [DEPTH];

    assign take = start && !busy;
    assign full = (r_fill == FULL_CNT);
    assign tok  = TOKEN_BITS'(i_item.token_value);

    always_comb begin
        n_cursor = r_cursor;
        n_fill   = r_fill;
        ctl.op   = rtb_pkg::CELL_HOLD;
        pos      = r_cursor;
        use_tok  = 1'b0;
        popped   = 1'b0;
        status   = rtb_pkg::ST_OK;
        unique case (i_item.func)
            rtb_pkg::FN_ADVANCE, rtb_pkg::FN_INSERT: begin
                if (i_item.func == rtb_pkg::FN_ADVANCE && r_cursor < r_fill) begin
                    n_cursor = r_cursor + ONE;
                end else if (!full) begin
                    ctl.op   = rtb_pkg::CELL_INS;
                    use_tok  = 1'b1;
                    n_cursor = r_cursor + ONE;
                    n_fill   = r_fill + ONE;
                end else begin
                    status = rtb_pkg::ST_FULL;
                end
            end
            rtb_pkg::FN_POP: begin
                if (r_cursor == '0) begin
                    status = rtb_pkg::ST_ZERO;
                end else begin
                    ctl.op   = rtb_pkg::CELL_DEL;
                    popped   = 1'b1;
                    n_cursor = r_cursor - ONE;
                    n_fill   = r_fill - ONE;
                    pos      = r_cursor - ONE;
                end
            end
            rtb_pkg::FN_BACK: begin
                if (r_cursor == '0) begin
                    status = rtb_pkg::ST_ZERO;
                end else begin
                    n_cursor = r_cursor - ONE;
                end
            end
            default: status = rtb_pkg::ST_OK;
        endcase
        if (!take) begin
            ctl.op = rtb_pkg::CELL_HOLD;
        end
        ctl.sel_en = popped || (n_cursor != '0);
        sel_idx    = popped ? n_cursor : n_cursor - ONE;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        rtb_cell #(
            .IDX        (g),
            .CW         (CW),
            .TOKEN_BITS (TOKEN_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_pos       (pos),
            .i_sel_idx   (sel_idx),
            .i_tok       (tok),
            .i_left      (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right     (cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_value     (cell_val[g]),
            .o_sel_value (cell_sel[g])
        );
    end

    always_comb begin
        sel_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_or = sel_or | cell_sel[k];
        end
    end

    always_comb begin
        n_result.token_out  = use_tok ? rtb_pkg::OUT_TOK_W'(tok)
                                      : rtb_pkg::OUT_TOK_W'(sel_or);
        n_result.took_input = use_tok;
        n_result.cursor     = rtb_pkg::COUNT_W'(n_cursor);
        n_result.fill       = rtb_pkg::COUNT_W'(n_fill);
        n_result.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_valid  <= 1'b0;
            r_cursor <= '0;
            r_fill   <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= take;
            if (take) begin
                r_cursor <= n_cursor;
                r_fill   <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* design/rtb_cell.sv */
// One storage cell of the token chain: holds one token, loads from its
// lower or upper neighbor or the input token. Depends on rtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtb_cell #(
    parameter int IDX        = 0,
    parameter int CW         = 7,
    parameter int TOKEN_BITS = rtb_pkg::TOKEN_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire rtb_pkg::t_cell_ctl    i_ctl,
    input  wire logic [CW-1:0]         i_pos,
    input  wire logic [CW-1:0]         i_sel_idx,
    input  wire logic [TOKEN_BITS-1:0] i_tok,
    input  wire logic [TOKEN_BITS-1:0] i_left,
    input  wire logic [TOKEN_BITS-1:0] i_right,
    output logic [TOKEN_BITS-1:0]      o_value,
    output logic [TOKEN_BITS-1:0]      o_sel_value
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [TOKEN_BITS-1:0] r_value;
    logic [TOKEN_BITS-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            rtb_pkg::CELL_INS: begin
                if (MY_IDX > i_pos) begin
                    n_value = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_value = i_tok;
                end
            end
            rtb_pkg::CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value     = r_value;
    assign o_sel_value = (i_ctl.sel_en && (MY_IDX == i_sel_idx)) ? r_value
                                                                 : '0;

endmodule
`default_nettype wire

/* test/rewindable_token_buffer_unit_tb.sv */
// Testbench for rewindable_token_buffer_unit: runs insert, advance, pop and back items
// through the block and checks every result against a shadow buffer kept here.
// Depends on rtb_pkg and the rewindable_token_buffer_unit RTL.
`timescale 1ns / 1ps
module rewindable_token_buffer_unit_tb;
    import rtb_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE       = 5;

    typedef struct {
        t_in         item;
        int unsigned gap;
        bit          drain;
    } op_req_t;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_item  = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_result;

    op_req_t     op_queue[$];
    t_out        buffer_views[$];
    logic [31:0] shadow_cells [DEPTH];
    int unsigned shadow_cursor = 0;
    int unsigned shadow_fill   = 0;

    int unsigned total_items = 0;
    int unsigned n_accepted  = 0;
    int unsigned n_done      = 0;
    int unsigned idle_cycles = 0;
    int unsigned err_count   = 0;
    int unsigned n_full = 0, n_zero = 0, n_took = 0, n_popped = 0, peak_fill = 0;
    bit          timed_out;

    rewindable_token_buffer_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit shadow_insert(logic [31:0] tok);
        if (shadow_fill >= DEPTH) return 1'b0;
        for (int unsigned i = shadow_fill; i > shadow_cursor; i--)
            shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[shadow_cursor] = tok;
        shadow_fill++;
        shadow_cursor++;
        return 1'b1;
    endfunction

    function automatic void step_shadow_buffer(t_in it);
        t_out        view;
        bit          popped;
        logic [31:0] pop_tok;
        view    = '0;
        popped  = 1'b0;
        pop_tok = '0;
        view.status = ST_OK;
        case (it.func)
            FN_ADVANCE, FN_INSERT: begin
                if (it.func == FN_ADVANCE && shadow_cursor < shadow_fill)
                    shadow_cursor++;
                else if (shadow_insert(it.token_value))
                    view.took_input = 1'b1;
                else
                    view.status = ST_FULL;
            end
            FN_POP: begin
                if (shadow_cursor == 0) begin
                    view.status = ST_ZERO;
                end else begin
                    shadow_cursor--;
                    shadow_fill--;
                    pop_tok = shadow_cells[shadow_cursor];
                    popped  = 1'b1;
                    for (int unsigned i = shadow_cursor; i < shadow_fill; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                end
            end
            default: begin
                if (shadow_cursor == 0) view.status = ST_ZERO;
                else shadow_cursor--;
            end
        endcase
        if (popped) view.token_out = pop_tok;
        else if (shadow_cursor > 0) view.token_out = shadow_cells[shadow_cursor - 1];
        view.cursor = shadow_cursor[COUNT_W-1:0];
        view.fill   = shadow_fill[COUNT_W-1:0];
        n_full   += (view.status == ST_FULL);
        n_zero   += (view.status == ST_ZERO);
        n_took   += view.took_input;
        n_popped += popped;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        buffer_views.push_back(view);
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_token();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_op(t_func f, logic [31:0] tok, bit calm, bit drain = 1'b0);
        op_req_t req;
        req.item.func        = f;
        req.item.token_value = tok;
        req.gap              = pick_gap(calm);
        req.drain            = drain;
        op_queue.push_back(req);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= 40)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // driver: holds start until the item is taken, then loads the next one
    always @(posedge i_clk) begin : drive_ops
        bit go;
        bit took_now;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            go       = start;
            took_now = start && !busy;
            if (took_now) begin
                step_shadow_buffer(i_item);
                n_accepted <= n_accepted + 1;
                go = 1'b0;
            end
            if (!go && op_queue.size() > 0) begin
                if (op_queue[0].gap > 0) begin
                    op_queue[0].gap--;
                end else if (!(op_queue[0].drain && (took_now || n_done != n_accepted))) begin
                    i_item <= op_queue[0].item;
                    void'(op_queue.pop_front());
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // monitor: results are single-cycle strobes, compared in order
    always @(posedge i_clk) begin : watch_results
        t_out want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid) begin
                n_done <= n_done + 1;
                if (buffer_views.size() == 0) begin
                    err_count++;
                    $error("result with no item outstanding: %p", o_result);
                end else begin
                    want = buffer_views.pop_front();
                    check_field("token_out", want.token_out, o_result.token_out);
                    check_field("took_input", want.took_input, o_result.took_input);
                    check_field("cursor", want.cursor, o_result.cursor);
                    check_field("fill", want.fill, o_result.fill);
                    check_field("status", want.status, o_result.status);
                end
            end
            idle_cycles <= (o_valid || (start && !busy)) ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n;
        int unsigned k;
        bit          calm;
        bit          first;

        // directed: empty-buffer errors, extremes, rewind and replay, middle insert and pop
        push_op(FN_POP,     32'h1234_5678, 1'b1);
        push_op(FN_BACK,    32'hFFFF_FFFF, 1'b1);
        push_op(FN_ADVANCE, 32'h0000_0000, 1'b1);
        push_op(FN_INSERT,  32'hFFFF_FFFF, 1'b1);
        push_op(FN_INSERT,  32'h8000_0001, 1'b0);
        push_op(FN_ADVANCE, 32'h7FFF_FFFE, 1'b0);
        push_op(FN_BACK,    32'h0,         1'b1);
        push_op(FN_BACK,    32'h0,         1'b1);
        push_op(FN_ADVANCE, 32'hDEAD_BEEF, 1'b1);
        push_op(FN_INSERT,  32'hA5A5_A5A5, 1'b1);
        push_op(FN_POP,     32'h0,         1'b0);
        push_op(FN_BACK,    32'h0,         1'b0);
        push_op(FN_POP,     32'h5A5A_5A5A, 1'b1, 1'b1);
        push_op(FN_BACK,    32'h0,         1'b1);
        push_op(FN_BACK,    32'h0,         1'b1);
        push_op(FN_BACK,    32'h0,         1'b1);
        push_op(FN_POP,     32'h0,         1'b1);
        push_op(FN_ADVANCE, 32'h0,         1'b1);
        push_op(FN_ADVANCE, 32'h0,         1'b1);
        push_op(FN_ADVANCE, 32'h0,         1'b0);
        push_op(FN_ADVANCE, 32'hFFFF_FFFF, 1'b0);
        push_op(FN_POP,     32'h0,         1'b0);

        first = 1'b1;
        n     = op_queue.size() + RANDOM_ITEMS;
        while (op_queue.size() < n) begin
            calm = ($urandom_range(0, 3) == 0);
            if (first || $urandom_range(0, 5) == 0)
                push_op(t_func'($urandom_range(0, 3)), pick_token(), calm, 1'b1);
            first = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(8, 70))
                        push_op($urandom_range(0, 3) == 0 ? FN_ADVANCE : FN_INSERT,
                                pick_token(), calm);
                end
                3, 4: begin
                    k = $urandom_range(1, 24);
                    repeat (k) push_op(FN_BACK, pick_token(), calm);
                    repeat (k + $urandom_range(0, 3)) push_op(FN_ADVANCE, pick_token(), calm);
                end
                5, 6: begin
                    repeat ($urandom_range(5, 40))
                        push_op($urandom_range(0, 5) == 0 ? FN_BACK : FN_POP,
                                pick_token(), calm);
                end
                7: begin
                    repeat ($urandom_range(20, 70)) push_op(FN_BACK, pick_token(), calm);
                    repeat (2) push_op(FN_POP, pick_token(), calm);
                    repeat ($urandom_range(1, 6)) push_op(FN_ADVANCE, pick_token(), calm);
                end
                default: begin
                    repeat ($urandom_range(3, 15))
                        push_op(t_func'($urandom_range(0, 3)), pick_token(), calm);
                end
            endcase
        end
        total_items = op_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while ((n_accepted != total_items || n_done != n_accepted) && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        timed_out = (idle_cycles >= IDLE_LIMIT);
        if (timed_out)
            $display("timeout: %0d of %0d items taken, %0d results", n_accepted, total_items,
                     n_done);
        else
            repeat (SETTLE) @(posedge i_clk);

        $display("ran %0d items, %0d results: %0d stored, %0d popped, peak fill %0d",
                 n_accepted, n_done, n_took, n_popped, peak_fill);
        $display("rejected: %0d on a full buffer, %0d at cursor zero; %0d mismatches",
                 n_full, n_zero, err_count);
        if (err_count == 0 && !timed_out)
            $display("rewindable_token_buffer_unit_tb OK");
        else
            $display("rewindable_token_buffer_unit_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
design/rtb_pkg.sv
design/rtb_cell.sv
design/rewindable_token_buffer_unit.sv
test/rewindable_token_buffer_unit_tb.sv
